[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[design/vrc_pkg.sv]
// ---------------------------------------------------------------------------
// vrc_pkg
// Widths, register indexes and hue sector codes of the rainbow color unit.
// ---------------------------------------------------------------------------
package vrc_pkg;

   localparam int VALUE_WIDTH = 32;            // used bits of sample and bounds
   localparam int WORD_WIDTH  = 32;            // sample and csr data port width
   localparam int DIFF_W      = VALUE_WIDTH + 1;
   localparam int DEN_W       = VALUE_WIDTH + 2; // 3 * span
   localparam int NUM_W       = VALUE_WIDTH + 4; // 14 * rest
   localparam int FRAC_BITS   = 16;
   localparam int INT_BITS    = 3;
   localparam int QUOT_W      = INT_BITS + FRAC_BITS;
   localparam int CHAN_W      = 8;

   localparam logic [CHAN_W-1:0] FULL_CHANNEL = 8'd255;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_HIGH = 2'd1;

   localparam logic [VALUE_WIDTH-1:0] RANGE_LOW_RESET  = VALUE_WIDTH'(0);
   localparam logic [VALUE_WIDTH-1:0] RANGE_HIGH_RESET = VALUE_WIDTH'(16711680);

   localparam logic [INT_BITS-1:0] SECTOR_RED_YELLOW   = 3'd0;
   localparam logic [INT_BITS-1:0] SECTOR_YELLOW_GREEN = 3'd1;
   localparam logic [INT_BITS-1:0] SECTOR_GREEN_CYAN   = 3'd2;
   localparam logic [INT_BITS-1:0] SECTOR_CYAN_BLUE    = 3'd3;
   localparam logic [INT_BITS-1:0] SECTOR_BLUE_VIOLET  = 3'd4;

   typedef logic [QUOT_W-1:0] hue_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } color_type;

   // low VALUE_WIDTH bits of a port word, sign-extended to difference width
   function automatic logic signed [DIFF_W-1:0] widen(input logic [WORD_WIDTH-1:0] w);
      logic [VALUE_WIDTH-1:0] v;
      v = VALUE_WIDTH'(w);
      return DIFF_W'(signed'(v));
   endfunction

   // (frac * 255 + half) >> FRAC_BITS, frac in 0..2^FRAC_BITS
   function automatic logic [CHAN_W-1:0] round_channel(input logic [FRAC_BITS:0] frac);
      logic [FRAC_BITS+CHAN_W:0] prod;
      prod = ((FRAC_BITS + CHAN_W + 1)'(frac) << CHAN_W) - (FRAC_BITS + CHAN_W + 1)'(frac)
             + ((FRAC_BITS + CHAN_W + 1)'(1) << (FRAC_BITS - 1));
      return prod[FRAC_BITS+CHAN_W-1:FRAC_BITS];
   endfunction

endpackage

[design/value_to_rainbow_color_unit.sv]
// ---------------------------------------------------------------------------
// value_to_rainbow_color_unit
// Maps a signed fixed-point sample to an RGB rainbow color between two bounds.
// ---------------------------------------------------------------------------
// Takes one Q16.16 sample word per clock unless halted and returns one 24-bit
// RGB word per sample, in order. range_high maps to red, range_low to violet
// (hue 280), samples outside the bounds clamp to the nearer end, and equal
// bounds give pure red. The long division of the hue resolves one quotient bit
// per pipeline stage over 19 stages; the whole pipeline moves together and
// halts only while a finished word waits on rsp_tready. The user must write the
// bounds through the csr port while the unit is idle; the unit does not enforce it.
`include "assert_macros.svh"

module value_to_rainbow_color_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [vrc_pkg::WORD_WIDTH-1:0]      req_tdata,  // [31:0] sample_value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [3*vrc_pkg::CHAN_W-1:0]        rsp_tdata,  // [7:0] red, [15:8] green,
                                                           // [23:16] blue
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vrc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vrc_pkg::WORD_WIDTH-1:0]      csr_data
);
   import vrc_pkg::*;

   logic [VALUE_WIDTH-1:0] range_low_ff, range_high_ff;
   logic                   advance;

   // stage 1: captured sample
   logic                          s1_valid_ff;
   logic [WORD_WIDTH-1:0]         s1_sample_ff;
   // stage 2: raw differences
   logic                          s2_valid_ff;
   logic signed [DIFF_W-1:0]      s2_num_ff, s2_den_ff;
   logic signed [DIFF_W-1:0]      s2_num_in, s2_den_in;
   // stage 3: span made positive
   logic                          s3_valid_ff;
   logic signed [DIFF_W-1:0]      s3_num_ff;
   logic [VALUE_WIDTH-1:0]        s3_den_ff;
   // stage 4: clamped distance from the red end
   logic                          s4_valid_ff;
   logic [VALUE_WIDTH-1:0]        s4_rest_ff, s4_den_ff;
   logic [VALUE_WIDTH-1:0]        s4_rest_in, s4_den_in;

   // divider: element 0 is the scaled operand stage, element k+1 follows step k
   logic                   div_valid_ff [0:QUOT_W];
   logic [NUM_W-1:0]       div_rem_ff   [0:QUOT_W];
   logic [DEN_W-1:0]       div_den_ff   [0:QUOT_W];
   hue_type                div_quot_ff  [0:QUOT_W];

   logic                   rsp_valid_ff;
   color_type              rsp_color_ff, rsp_color_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_color_ff;

   // bound registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RANGE_LOW:  range_low_ff  <= VALUE_WIDTH'(csr_data);
            CSR_RANGE_HIGH: range_high_ff <= VALUE_WIDTH'(csr_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      s2_num_in = widen(s1_sample_ff) - widen(WORD_WIDTH'(range_low_ff));
      s2_den_in = widen(WORD_WIDTH'(range_high_ff)) - widen(WORD_WIDTH'(range_low_ff));
   end

   // rest = span - distance, clamped; zero span forced to one so the divider sees 0/1
   always_comb begin
      logic signed [DIFF_W-1:0] den_s;
      den_s = signed'({1'b0, s3_den_ff});
      if (s3_den_ff == '0 || s3_num_ff >= den_s) begin
         s4_rest_in = '0;
      end else if (s3_num_ff <= 0) begin
         s4_rest_in = s3_den_ff;
      end else begin
         s4_rest_in = s3_den_ff - s3_num_ff[VALUE_WIDTH-1:0];
      end
      s4_den_in = (s3_den_ff == '0) ? VALUE_WIDTH'(1) : s3_den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         s4_valid_ff     <= 1'b0;
         div_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         s1_valid_ff     <= req_tvalid;
         s2_valid_ff     <= s1_valid_ff;
         s3_valid_ff     <= s2_valid_ff;
         s4_valid_ff     <= s3_valid_ff;
         div_valid_ff[0] <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sample_ff <= req_tdata;
         s2_num_ff    <= s2_num_in;
         s2_den_ff    <= s2_den_in;
         if (s2_den_ff < 0) begin
            s3_num_ff <= -s2_num_ff;
            s3_den_ff <= VALUE_WIDTH'(-s2_den_ff);
         end else begin
            s3_num_ff <= s2_num_ff;
            s3_den_ff <= VALUE_WIDTH'(s2_den_ff);
         end
         s4_rest_ff <= s4_rest_in;
         s4_den_ff  <= s4_den_in;
         // hue/60 = rest*14 / (span*3)
         div_rem_ff[0]  <= (NUM_W'(s4_rest_ff) << 4) - (NUM_W'(s4_rest_ff) << 1);
         div_den_ff[0]  <= (DEN_W'(s4_den_ff) << 1) + DEN_W'(s4_den_ff);
         div_quot_ff[0] <= '0;
      end
   end

   // restoring division, one quotient bit per stage: three integer bits
   // against 4d, 2d, d, then fraction bits with the remainder doubled
   for (genvar k = 0; k < QUOT_W; k++) begin : g_div
      localparam int SHIFT = (k < INT_BITS) ? (INT_BITS - 1 - k) : 0;
      logic [NUM_W-1:0] trial_rem, trial_den, rem_in;
      logic             bit_in;

      always_comb begin
         if (k < INT_BITS) begin
            trial_rem = div_rem_ff[k];
         end else begin
            trial_rem = {div_rem_ff[k][NUM_W-2:0], 1'b0};
         end
         trial_den = NUM_W'(div_den_ff[k]) << SHIFT;
         bit_in    = (trial_rem >= trial_den);
         rem_in    = bit_in ? (trial_rem - trial_den) : trial_rem;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            div_valid_ff[k+1] <= div_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_rem_ff[k+1]  <= rem_in;
            div_den_ff[k+1]  <= div_den_ff[k];
            div_quot_ff[k+1] <= {div_quot_ff[k][QUOT_W-2:0], bit_in};
         end
      end
   end

   // sector and fraction to channels
   always_comb begin
      logic [INT_BITS-1:0]  sector;
      logic [FRAC_BITS-1:0] frac;
      logic [CHAN_W-1:0]    rise, fall;
      sector = div_quot_ff[QUOT_W][QUOT_W-1:FRAC_BITS];
      frac   = div_quot_ff[QUOT_W][FRAC_BITS-1:0];
      rise   = round_channel({1'b0, frac});
      fall   = round_channel(((FRAC_BITS + 1)'(1) << FRAC_BITS) - {1'b0, frac});
      case (sector)
         SECTOR_RED_YELLOW:   rsp_color_in = '{blue: '0, green: rise, red: FULL_CHANNEL};
         SECTOR_YELLOW_GREEN: rsp_color_in = '{blue: '0, green: FULL_CHANNEL, red: fall};
         SECTOR_GREEN_CYAN:   rsp_color_in = '{blue: rise, green: FULL_CHANNEL, red: '0};
         SECTOR_CYAN_BLUE:    rsp_color_in = '{blue: FULL_CHANNEL, green: fall, red: '0};
         default:             rsp_color_in = '{blue: FULL_CHANNEL, green: '0, red: rise};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_color_ff <= rsp_color_in;
      end
   end

   `ASSERT_SAME(a_rest_within_span, s4_valid_ff, s4_rest_ff <= s4_den_ff)
   `ASSERT_SAME(a_rem_below_divisor, div_valid_ff[QUOT_W], NUM_W'(div_den_ff[QUOT_W]) > div_rem_ff[QUOT_W])
   `ASSERT_SAME(a_hue_sector_range, div_valid_ff[QUOT_W], div_quot_ff[QUOT_W][QUOT_W-1:FRAC_BITS] <= SECTOR_BLUE_VIOLET)
   `ASSERT_NEXT(a_stall_holds_word, rsp_valid_ff && !rsp_tready, rsp_valid_ff && $stable(rsp_color_ff))

endmodule

[sim/value_to_rainbow_color_unit_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// value_to_rainbow_color_unit_tb
// Streams Q16.16 samples through the rainbow color unit and checks each RGB word.
// ---------------------------------------------------------------------------
// The bounds start at the reset values and are then set through the csr port
// between traffic phases, among them equal bounds, reversed bounds and the full signed range.
// A behavioral hue predictor works out the expected color of every accepted
// sample. Both stream sides idle at random. One phase holds off the result side
// long enough to back up the pipeline, and one phase runs with no idling.
// ---------------------------------------------------------------------------
module value_to_rainbow_color_unit_tb;
   import vrc_pkg::*;

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 6;
   localparam int PIPE_LATENCY    = 25;
   localparam int SETTLE_CYCLES   = PIPE_LATENCY + 15;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int IDLE_PERCENT    = 17;
   localparam int PRINT_LIMIT     = 100;

   localparam longint unsigned HUE_SCALE_NUM = 14;   // 280 / 60 = 14 / 3
   localparam longint unsigned HUE_SCALE_DEN = 3;
   localparam longint unsigned CHANNEL_TOP   = 255;
   localparam longint VALUE_MIN = -(longint'(1) << (VALUE_WIDTH - 1));
   localparam longint VALUE_MAX = (longint'(1) << (VALUE_WIDTH - 1)) - 1;

   // indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_B = 2'd3;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [WORD_WIDTH-1:0]    req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [3*CHAN_W-1:0]      rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index  = '0;
   logic [WORD_WIDTH-1:0]    csr_data   = '0;

   logic [WORD_WIDTH-1:0]    bound_low  = RANGE_LOW_RESET;
   logic [WORD_WIDTH-1:0]    bound_high = RANGE_HIGH_RESET;
   color_type                expected_colors[$];
   int unsigned              error_count   = 0;
   bit                       feed_idle_on  = 1'b1;
   bit                       sink_idle_on  = 1'b1;
   int unsigned              hold_requests = 0;
   int unsigned              holds_served  = 0;
   int unsigned              hold_left     = 0;

   always #HALF_PERIOD clock = ~clock;

   value_to_rainbow_color_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 0..2^FRAC_BITS scaled to 0..255, round half up
   function automatic logic [CHAN_W-1:0] channel_level(input longint unsigned level);
      return CHAN_W'((level * CHANNEL_TOP + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
   endfunction

   function automatic color_type rainbow_color(input logic [WORD_WIDTH-1:0] sample_word,
                                               input logic [WORD_WIDTH-1:0] low,
                                               input logic [WORD_WIDTH-1:0] high);
      longint            offset, span;
      longint unsigned   remaining, dividend, divisor, rem, hue6, frac;
      logic [INT_BITS-1:0] sector;
      logic [CHAN_W-1:0] rising, falling;
      color_type         color;
      int                step;
      offset = longint'(signed'(sample_word)) - longint'(signed'(low));
      span   = longint'(signed'(high)) - longint'(signed'(low));
      if (span < 0) begin
         offset = -offset;
         span   = -span;
      end
      // remaining = span * (1 - t), with t clamped to [0,1]
      if (span == 0 || offset >= span)
         remaining = 0;
      else if (offset <= 0)
         remaining = span;
      else
         remaining = span - offset;
      hue6 = 0;
      if (remaining != 0) begin
         dividend = remaining * HUE_SCALE_NUM;
         divisor  = span * HUE_SCALE_DEN;
         hue6     = dividend / divisor;
         rem      = dividend % divisor;
         for (step = 0; step < FRAC_BITS; step++) begin
            rem  = rem << 1;
            hue6 = hue6 << 1;
            if (rem >= divisor) begin
               rem  = rem - divisor;
               hue6 = hue6 | 1;
            end
         end
      end
      sector  = INT_BITS'(hue6 >> FRAC_BITS);
      frac    = hue6 & ((longint'(1) << FRAC_BITS) - 1);
      rising  = channel_level(frac);
      falling = channel_level((longint'(1) << FRAC_BITS) - frac);
      case (sector)
         SECTOR_RED_YELLOW: begin
            color.red = FULL_CHANNEL; color.green = rising;       color.blue = '0;
         end
         SECTOR_YELLOW_GREEN: begin
            color.red = falling;      color.green = FULL_CHANNEL; color.blue = '0;
         end
         SECTOR_GREEN_CYAN: begin
            color.red = '0;           color.green = FULL_CHANNEL; color.blue = rising;
         end
         SECTOR_CYAN_BLUE: begin
            color.red = '0;           color.green = falling;      color.blue = FULL_CHANNEL;
         end
         default: begin
            color.red = rising;       color.green = '0;           color.blue = FULL_CHANNEL;
         end
      endcase
      return color;
   endfunction

   task automatic report_mismatch(input string note);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("ERROR at %0t ns: %s", $time, note);
   endtask

   // result side: random ready, long hold-off on request, in-order compare
   always @(posedge clock) begin : result_sink
      color_type got, want;
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(sink_idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = color_type'(rsp_tdata);
         if (expected_colors.size() == 0) begin
            report_mismatch($sformatf("result word %06h with no sample pending", rsp_tdata));
         end else begin
            want = expected_colors.pop_front();
            if (got.red != want.red)
               report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
            if (got.green != want.green)
               report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
            if (got.blue != want.blue)
               report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
         end
      end
   end

   task automatic send_sample(input logic [WORD_WIDTH-1:0] sample_word);
      while (feed_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample_word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_colors.insert(expected_colors.size(),
                             rainbow_color(sample_word, bound_low, bound_high));
   endtask

   // leaves csr_valid high; the caller lowers it
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [WORD_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_RANGE_LOW:  bound_low  = data;
         CSR_RANGE_HIGH: bound_high = data;
         default: ;
      endcase
   endtask

   task automatic set_bounds(input logic [WORD_WIDTH-1:0] low,
                             input logic [WORD_WIDTH-1:0] high);
      write_register(CSR_RANGE_LOW, low);
      write_register(CSR_RANGE_HIGH, high);
      // a write to an unmapped index must not disturb either bound
      write_register($urandom_range(1) ? CSR_UNMAPPED_A : CSR_UNMAPPED_B, $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_colors.size() != 0) @(posedge clock);
   endtask

   // mostly inside the current bounds, some on them, some outside, some anywhere
   function automatic logic [WORD_WIDTH-1:0] pick_sample();
      longint          floor_v, ceil_v, value;
      longint unsigned extent;
      int unsigned     roll;
      floor_v = longint'(signed'(bound_low));
      ceil_v  = longint'(signed'(bound_high));
      if (floor_v > ceil_v) begin
         value   = floor_v;
         floor_v = ceil_v;
         ceil_v  = value;
      end
      extent = ceil_v - floor_v;
      roll   = $urandom_range(99);
      if (roll < 70)
         value = floor_v + longint'({$urandom, $urandom} % (extent + 1));
      else if (roll < 78)
         value = $urandom_range(1) ? floor_v : ceil_v;
      else if (roll < 84)
         value = floor_v - longint'($urandom_range(1, 1 << 20));
      else if (roll < 90)
         value = ceil_v + longint'($urandom_range(1, 1 << 20));
      else
         value = int'($urandom);
      if (value < VALUE_MIN) value = VALUE_MIN;
      if (value > VALUE_MAX) value = VALUE_MAX;
      return WORD_WIDTH'(value);
   endfunction

   task automatic test_reset_bounds();
      logic [WORD_WIDTH-1:0] corner [9];
      longint                span;
      int                    sector_idx;
      corner = '{32'h0000_0000, RANGE_HIGH_RESET, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001,
                 RANGE_HIGH_RESET - 1};
      foreach (corner[i]) send_sample(corner[i]);
      // middle of each hue sector, red end first
      span = longint'(RANGE_HIGH_RESET);
      for (sector_idx = 0; sector_idx < 5; sector_idx++)
         send_sample(WORD_WIDTH'(span - span * (6 * sector_idx + 3) / 28));
      wait_drained();
   endtask

   task automatic test_equal_bounds();
      logic [WORD_WIDTH-1:0] level;
      level = $urandom;
      set_bounds(level, level);
      send_sample(level);
      send_sample(level + 1);
      send_sample(32'h8000_0000);
      wait_drained();
   endtask

   task automatic test_reversed_bounds();
      set_bounds(32'h00FF_0000, 32'h0000_0000);   // 255.0 down to 0.0
      send_sample(32'h0000_0000);
      send_sample(32'h00FF_0000);
      send_sample(32'h0064_0000);
      send_sample(32'hFFFB_0000);
      wait_drained();
   endtask

   task automatic test_extreme_bounds();
      set_bounds(32'h8000_0000, 32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_FFFF);
      wait_drained();
   endtask

   task automatic test_random_bounds(input int phases, input int per_phase);
      longint low_v, high_v;
      int     phase, n;
      for (phase = 0; phase < phases; phase++) begin
         case (phase % 6)
            0: begin
               low_v  = int'($urandom);
               high_v = int'($urandom);
            end
            1: begin
               low_v  = -longint'($urandom_range(1000 << 16));
               high_v = longint'($urandom_range(1000 << 16));
            end
            2: begin
               low_v  = int'($urandom);
               high_v = low_v + longint'($urandom_range(1, 40));
               if (high_v > VALUE_MAX) high_v = low_v - 40;
            end
            3: begin
               low_v  = longint'($urandom_range(1000 << 16));
               high_v = -longint'($urandom_range(1000 << 16));
            end
            4: begin
               low_v  = (phase % 12 == 4) ? VALUE_MIN : VALUE_MAX;
               high_v = (phase % 12 == 4) ? VALUE_MAX : VALUE_MIN;
            end
            default: begin
               low_v  = int'($urandom);
               high_v = low_v;
            end
         endcase
         set_bounds(WORD_WIDTH'(low_v), WORD_WIDTH'(high_v));
         for (n = 0; n < per_phase; n++) send_sample(pick_sample());
         wait_drained();
      end
   endtask

   // result side stalls long enough that the pipeline fills and stops taking words
   task automatic test_backpressure();
      int n;
      set_bounds(32'hFF38_0000, 32'h00C8_0000);   // -200.0 .. 200.0
      hold_requests = hold_requests + 1;
      for (n = 0; n < 80; n++) send_sample(pick_sample());
      wait_drained();
   endtask

   task automatic test_steady_stream();
      int n;
      set_bounds(-$urandom_range(1 << 24), $urandom_range(1 << 24));
      feed_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      for (n = 0; n < 150; n++) send_sample(pick_sample());
      wait_drained();
      feed_idle_on = 1'b1;
      sink_idle_on = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_bounds();
      test_equal_bounds();
      test_reversed_bounds();
      test_extreme_bounds();
      test_random_bounds(12, 100);
      test_backpressure();
      test_steady_stream();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("value_to_rainbow_color_unit_tb passed");
      else
         $display("value_to_rainbow_color_unit_tb failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("value_to_rainbow_color_unit_tb failed");
      $finish;
   end

endmodule
